FILE: design/urrb_pkg.sv
// Shared types and constants for the UART receiver with receive ring.
package urrb_pkg;

	localparam int unsigned BitPeriodW = 20;
	localparam int unsigned RingSizeW  = 9;
	localparam int unsigned CfgDataW   = 20;
	localparam int unsigned CfgIndexW  = 2;

	// Configuration register indexes
	typedef enum logic [CfgIndexW-1:0] {
		CFG_BIT_PERIOD  = 2'd0,
		CFG_PARITY_MODE = 2'd1,
		CFG_STOP_BITS   = 2'd2,
		CFG_RING_SIZE   = 2'd3
	} cfg_index_t;

	// Parity mode codes; other codes mean no parity bit
	localparam logic [1:0] PAR_EVEN = 2'd1;
	localparam logic [1:0] PAR_ODD  = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_DATA,
		PH_PARITY,
		PH_STOPCHK,
		PH_FAILWAIT,
		PH_EXTRA
	} phase_t;

	// Per-tick event from the receiver to the ring and the result stage
	typedef struct packed {
		logic       stored;
		logic       ferr;
		logic [7:0] data;
	} rx_evt_t;

endpackage

FILE: design/urrb_rx.sv
// Receiver state machine: start hunt, data sampling, optional parity bit, stop check, stop wait.
module urrb_rx
	import urrb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  tick,
	input  logic                  rx_level,
	input  logic [BitPeriodW-1:0] bit_period,
	input  logic [1:0]            parity_mode,
	input  logic [1:0]            stop_bits,
	output rx_evt_t               evt
);

	phase_t                phase_q, phase_d;
	logic [BitPeriodW-1:0] timer_q, timer_d;
	logic [3:0]            bit_idx_q, bit_idx_d;
	logic [7:0]            shift_q, shift_d;

	logic [BitPeriodW-1:0] eighth;
	logic [BitPeriodW-1:0] wait_bit;
	logic [BitPeriodW-1:0] wait_eighth;
	logic [3:0]            extra;
	logic                  go_extra;
	logic                  go_idle;

	assign eighth      = bit_period >> 3;
	assign wait_bit    = (bit_period == '0) ? BitPeriodW'(1) : bit_period;
	assign wait_eighth = (eighth == '0) ? BitPeriodW'(1) : eighth;
	assign extra       = (stop_bits > 2'd1) ? ({2'b00, stop_bits} - 4'd1) : 4'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			timer_q   <= '0;
			bit_idx_q <= '0;
			shift_q   <= '0;
		end else if (tick) begin
			phase_q   <= phase_d;
			timer_q   <= timer_d;
			bit_idx_q <= bit_idx_d;
			shift_q   <= shift_d;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		timer_d    = timer_q;
		bit_idx_d  = bit_idx_q;
		shift_d    = shift_q;
		go_extra   = 1'b0;
		go_idle    = 1'b0;
		evt.stored = 1'b0;
		evt.ferr   = 1'b0;
		evt.data   = shift_q;

		if (phase_q == PH_IDLE) begin
			go_idle = 1'b1;
		end else if (timer_q > BitPeriodW'(1)) begin
			timer_d = timer_q - BitPeriodW'(1);
		end else begin
			timer_d = '0;
			unique case (phase_q)
				PH_DATA: begin
					shift_d[bit_idx_q[2:0]] = rx_level;
					bit_idx_d = bit_idx_q + 4'd1;
					if (bit_idx_d >= 4'd8) begin
						bit_idx_d = '0;
						phase_d = (parity_mode == PAR_EVEN || parity_mode == PAR_ODD)
							? PH_PARITY : PH_STOPCHK;
					end
					timer_d = wait_bit;
				end
				PH_PARITY: begin
					phase_d   = PH_STOPCHK;
					bit_idx_d = '0;
					timer_d   = wait_bit;
				end
				PH_STOPCHK: begin
					if (rx_level) begin
						evt.stored = 1'b1;
						go_extra   = 1'b1;
					end else begin
						bit_idx_d = bit_idx_q + 4'd1;
						if (bit_idx_d >= 4'd8) begin
							evt.ferr = 1'b1;
							phase_d  = PH_FAILWAIT;
						end
						timer_d = wait_eighth;
					end
				end
				PH_FAILWAIT: begin
					go_extra = 1'b1;
				end
				PH_EXTRA: begin
					if (bit_idx_q > 4'd0) begin
						bit_idx_d = bit_idx_q - 4'd1;
					end
					if (bit_idx_d == 4'd0) begin
						go_idle = 1'b1;
					end else begin
						timer_d = wait_bit;
					end
				end
				default: begin
					go_idle = 1'b1;
				end
			endcase
		end

		// Extra stop bits, if any, then back to hunting
		if (go_extra) begin
			if (extra == 4'd0) begin
				go_idle = 1'b1;
			end else begin
				phase_d   = PH_EXTRA;
				bit_idx_d = extra;
				timer_d   = wait_bit;
			end
		end

		// Hunt: a low line starts the next frame in this same tick
		if (go_idle) begin
			phase_d   = PH_IDLE;
			timer_d   = '0;
			bit_idx_d = '0;
			if (!rx_level) begin
				phase_d = PH_DATA;
				shift_d = '0;
				timer_d = wait_bit;
			end
		end
	end

endmodule

FILE: design/urrb_ring.sv
// Receive ring: byte memory with write and read indexes and fill level.
module urrb_ring
	import urrb_pkg::*;
#(
	parameter int unsigned RING_DEPTH = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick,
	input  logic                 read_request,
	input  rx_evt_t              evt,
	input  logic [RingSizeW-1:0] ring_size,
	output logic                 pop,
	output logic [7:0]           available,
	output logic [7:0]           rd_data_s1
);

	localparam int unsigned IW = $clog2(RING_DEPTH);
	localparam int unsigned AW = IW + 1;

	logic [7:0]    mem [RING_DEPTH];
	logic [IW-1:0] wr_idx_q;
	logic [IW-1:0] rd_idx_q;
	logic [AW-1:0] size_clip;
	logic [AW-1:0] eff_size;
	logic [AW-1:0] wr_next;
	logic [AW-1:0] rd_next;
	logic [AW:0]   avail_full;

	always_comb begin
		if (32'(ring_size) >= RING_DEPTH) begin
			size_clip = AW'(RING_DEPTH);
		end else begin
			size_clip = AW'(ring_size);
		end
		eff_size = (size_clip == '0) ? AW'(1) : size_clip;
	end

	assign wr_next = {1'b0, wr_idx_q} + AW'(1);
	assign rd_next = {1'b0, rd_idx_q} + AW'(1);

	always_comb begin
		if (wr_idx_q >= rd_idx_q) begin
			avail_full = (AW+1)'(wr_idx_q) - (AW+1)'(rd_idx_q);
		end else begin
			avail_full = (AW+1)'(wr_idx_q) + (AW+1)'(eff_size) - (AW+1)'(rd_idx_q);
		end
	end

	assign available = 8'(avail_full);
	assign pop       = read_request && (avail_full != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
		end else if (tick) begin
			if (evt.stored) begin
				wr_idx_q <= (wr_next >= eff_size) ? '0 : wr_next[IW-1:0];
			end
			if (pop) begin
				rd_idx_q <= (rd_next >= eff_size) ? '0 : rd_next[IW-1:0];
			end
		end
	end

	// Read sees the old entry when the same entry is written in that cycle
	always_ff @(posedge clk) begin
		if (tick && evt.stored) begin
			mem[wr_idx_q] <= evt.data;
		end
		if (tick && pop) begin
			rd_data_s1 <= mem[rd_idx_q];
		end
	end

endmodule

FILE: design/uart_receiver_ring_buffer_unit.sv
// Top level: UART receiver (8N1 by default) with a receive ring and stream ports.
//
// Usage:
//   Each request on the s_axis channel is one clock tick of the serial line:
//   tdata[0] is the sampled receive level, tdata[1] a read request that pops
//   one byte from the ring if any is held. Every request gives exactly one
//   result on m_axis: the popped byte (zero when nothing was popped), a read
//   valid flag, the fill level before the pop, and pulses for a stored byte
//   and for a framing error (stop bit never seen high; byte dropped).
//   Timing of the serial frame counts requests, not clocks.
// Latency and throughput:
//   A result is registered and appears in the cycle after its request is taken.
//   One request per cycle is sustained while results drain: the state machine
//   steps once per request and the ring memory takes one write and one read per
//   cycle, read data registered. A pop and a store in one request see the ring as it was before both.
// Stall:
//   s_axis_tready drops only while a result waits and m_axis_tready is low;
//   the result register, the receiver and the ring then hold.
// Reset:
//   arst_n clears the receiver to start hunting, both ring indexes and the
//   result valid flag, and loads the register defaults. The ring memory is not
//   cleared: bytes are only read after they are written.
module uart_receiver_ring_buffer_unit
	import urrb_pkg::*;
#(
	parameter int unsigned RING_DEPTH = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Tick requests
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,   // [0] rx_level, [1] read_request
	// Results
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [23:0]          m_axis_tdata,   // [7:0] read_data, [8] read_valid,
	                                             // [16:9] available, [17] byte_stored,
	                                             // [18] framing_error
	// Configuration writes
	input  logic                 cfg_we,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data
);

	logic                  tick;
	logic                  rx_level;
	logic                  read_request;

	logic [BitPeriodW-1:0] bit_period_q;
	logic [1:0]            parity_mode_q;
	logic [1:0]            stop_bits_q;
	logic [RingSizeW-1:0]  ring_size_q;

	rx_evt_t               evt;
	logic                  pop;
	logic [7:0]            available;
	logic [7:0]            rd_data_s1;

	logic                  out_valid_q;
	logic                  read_valid_s1;
	logic [7:0]            available_s1;
	logic                  stored_s1;
	logic                  ferr_s1;

	assign rx_level     = s_axis_tdata[0];
	assign read_request = s_axis_tdata[1];

	// Take a new tick whenever the result slot is free or being drained
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign tick          = s_axis_tvalid && s_axis_tready;

	// Register writes; the default arm leaves everything alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q  <= BitPeriodW'(694);
			parity_mode_q <= 2'd0;
			stop_bits_q   <= 2'd1;
			ring_size_q   <= RingSizeW'(256);
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_BIT_PERIOD:  bit_period_q  <= cfg_data[BitPeriodW-1:0];
				CFG_PARITY_MODE: parity_mode_q <= cfg_data[1:0];
				CFG_STOP_BITS:   stop_bits_q   <= cfg_data[1:0];
				CFG_RING_SIZE:   ring_size_q   <= cfg_data[RingSizeW-1:0];
				default: ;
			endcase
		end
	end

	urrb_rx u_rx (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick        (tick),
		.rx_level    (rx_level),
		.bit_period  (bit_period_q),
		.parity_mode (parity_mode_q),
		.stop_bits   (stop_bits_q),
		.evt         (evt)
	);

	urrb_ring #(
		.RING_DEPTH (RING_DEPTH)
	) u_ring (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick         (tick),
		.read_request (read_request),
		.evt          (evt),
		.ring_size    (ring_size_q),
		.pop          (pop),
		.available    (available),
		.rd_data_s1   (rd_data_s1)
	);

	// Result register; the popped byte arrives from the memory read register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			read_valid_s1 <= pop;
			available_s1  <= available;
			stored_s1     <= evt.stored;
			ferr_s1       <= evt.ferr;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b00000, ferr_s1, stored_s1, available_s1, read_valid_s1,
		read_valid_s1 ? rd_data_s1 : 8'h00};

endmodule

FILE: design/urrb_checker.sv
// Port-level checks for the UART receiver ring unit, bound to the top level.
module urrb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// Drive zero data when nothing was popped
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'h00)
		else $error("read_data not zero without read_valid");

	// Store and framing error exclude each other
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[17] && m_axis_tdata[18]))
		else $error("byte_stored and framing_error together");

	// A store is never followed directly by another store
	a_store_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tdata[17]
		|=> !(m_axis_tvalid && m_axis_tdata[17]))
		else $error("byte_stored on consecutive ticks");

endmodule

bind uart_receiver_ring_buffer_unit urrb_checker u_urrb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
